// ===== rtl/hsc_pkg.sv =====
// Shared types, code table and bit-placement functions for the Hamming SECDED codec.
// No dependencies; used by every module of the codec.
package hsc_pkg;

    localparam int WORD_W    = 32;
    localparam int POS_W     = 6;
    localparam int CODE_W    = 3;
    localparam int SYN_W     = 5;
    localparam int RBITS_W   = 3;
    localparam int DBITS_W   = 5;
    localparam int DATA_MAX  = 26;
    localparam int USER_W    = 8;

    // Byte address of the code_type register on the configuration port.
    localparam logic [2:0] ADDR_CODE_TYPE = 3'd0;

    typedef logic [CODE_W-1:0] code_sel_t;

    localparam code_sel_t CODE_H74   = 3'd0;
    localparam code_sel_t CODE_H84   = 3'd1;
    localparam code_sel_t CODE_H1511 = 3'd2;
    localparam code_sel_t CODE_H1611 = 3'd3;
    localparam code_sel_t CODE_H3126 = 3'd4;
    localparam code_sel_t CODE_H3226 = 3'd5;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic               ext;
        logic [POS_W-1:0]   length;
        logic [DBITS_W-1:0] dbits;
        logic [RBITS_W-1:0] rbits;
    } code_desc_t;

    typedef struct packed {
        logic [SYN_W-1:0] syn;
        logic             par;
    } syn_info_t;

    typedef logic [SYN_W-1:0] bit_idx_t;

    // Bit index of each data bit in the codeword: every index i whose position
    // i+1 is not a power of two, in ascending order.
    localparam bit_idx_t DATA_IDX [DATA_MAX] = '{
        5'd2,  5'd4,  5'd5,  5'd6,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
        5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
        5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30
    };

    function automatic code_desc_t code_desc(code_sel_t c);
        code_desc_t d;
        d = '0;
        unique case (c)
            CODE_H74:   d = '{1'b1, 1'b0, 6'd7,  5'd4,  3'd3};
            CODE_H84:   d = '{1'b1, 1'b1, 6'd8,  5'd4,  3'd3};
            CODE_H1511: d = '{1'b1, 1'b0, 6'd15, 5'd11, 3'd4};
            CODE_H1611: d = '{1'b1, 1'b1, 6'd16, 5'd11, 3'd4};
            CODE_H3126: d = '{1'b1, 1'b0, 6'd31, 5'd26, 3'd5};
            CODE_H3226: d = '{1'b1, 1'b1, 6'd32, 5'd26, 3'd5};
            default:    d = '0;
        endcase
        return d;
    endfunction

    // Low 'length' bits set.
    function automatic logic [WORD_W-1:0] len_mask(code_desc_t d);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = (i < int'(d.length));
        end
        return m;
    endfunction

    // Positions 1..2^r-1, the ones covered by the syndrome.
    function automatic logic [WORD_W-1:0] ham_mask(code_desc_t d);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = (i < ((1 << d.rbits) - 1));
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] data_mask(code_desc_t d);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = (i < int'(d.dbits));
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] scatter(logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] cw;
        cw = '0;
        for (int k = 0; k < DATA_MAX; k++) begin
            cw[DATA_IDX[k]] = data[k];
        end
        return cw;
    endfunction

    function automatic logic [WORD_W-1:0] gather(logic [WORD_W-1:0] cw);
        logic [WORD_W-1:0] data;
        data = '0;
        for (int k = 0; k < DATA_MAX; k++) begin
            data[k] = cw[DATA_IDX[k]];
        end
        return data;
    endfunction

endpackage

// ===== rtl/hsc_syndrome.sv =====
// Syndrome and overall parity of a codeword for the selected code.
// Depends on hsc_pkg.
module hsc_syndrome (
    input  hsc_pkg::code_sel_t         code,
    input  logic [hsc_pkg::WORD_W-1:0] cw,
    output hsc_pkg::syn_info_t         info
);
    import hsc_pkg::*;

    logic [WORD_W-1:0] hw;
    logic [SYN_W-1:0]  syn;

    assign hw = cw & ham_mask(code_desc(code));

    // One parity tree per syndrome bit: position p feeds bit j when p has bit j set.
    always_comb
    begin
        syn = '0;
        for (int p = 1; p < WORD_W; p++) begin
            for (int j = 0; j < SYN_W; j++) begin
                if (((p >> j) & 1) == 1) begin
                    syn[j] = syn[j] ^ hw[p-1];
                end
            end
        end
    end

    assign info.syn = syn;
    assign info.par = ^cw;

endmodule

// ===== rtl/hamming_secded_codec.sv =====
// Hamming SECDED codec: three-stage pipeline, one word per cycle while m_tready is high.
// Each word passes through the stage 1, stage 2 and stage 3 registers in turn; m_tvalid is
// the stage 3 valid bit. A new word can be taken while earlier words are still in flight.
// Every stage advances when the one after it is empty or moving, so stalls lose nothing.
// Reset (rst_n low, asynchronous) empties the pipeline and sets code_type to (7,4).
// Depends on hsc_pkg and hsc_syndrome.
module hamming_secded_codec (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input words
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [hsc_pkg::WORD_W-1:0]  s_tdata,   // [31:0] word_in
    input  logic                        s_tuser,   // [0] command
    // result words
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hsc_pkg::WORD_W-1:0]  m_tdata,   // [31:0] word_out
    output logic [hsc_pkg::USER_W-1:0]  m_tuser    // [0] corrected, [6:1] fix_position,
                                                   // [7] uncorrectable
);
    import hsc_pkg::*;

    // ---------------------------------------------------------------
    // Configuration register. paddr[2] selects the register word.
    // ---------------------------------------------------------------
    code_sel_t code_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            code_reg <= CODE_H74;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == ADDR_CODE_TYPE[2])) begin
            code_reg <= pwdata[CODE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_CODE_TYPE[2]) ? {{(32-CODE_W){1'b0}}, code_reg} : '0;

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage takes a word when it is empty or
    // its current word moves on in the same cycle.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic st1_ready, st2_ready, st3_ready;

    assign st3_ready = !v3_reg || m_tready;
    assign st2_ready = !v2_reg || st3_ready;
    assign st1_ready = !v1_reg || st2_ready;
    assign s_tready  = st1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                v1_reg <= s_tvalid;
            end
            if (st2_ready) begin
                v2_reg <= v1_reg;
            end
            if (st3_ready) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: place data bits into the codeword (encode) or drop the
    // bits above the code length (decode). Unused code types give zero.
    // ---------------------------------------------------------------
    code_desc_t        desc1;
    cmd_t              cmd_in;
    logic [WORD_W-1:0] cw1_next;
    logic [WORD_W-1:0] cw1_reg;
    cmd_t              cmd1_reg;
    code_sel_t         code1_reg;

    assign desc1  = code_desc(code_reg);
    assign cmd_in = cmd_t'(s_tuser);

    always_comb
    begin
        if (!desc1.valid) begin
            cw1_next = '0;
        end else if (cmd_in == CMD_DECODE) begin
            cw1_next = s_tdata & len_mask(desc1);
        end else begin
            cw1_next = scatter(s_tdata & data_mask(desc1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && st1_ready) begin
            cw1_reg   <= cw1_next;
            cmd1_reg  <= cmd_in;
            code1_reg <= code_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: syndrome over the Hamming positions and overall parity.
    // ---------------------------------------------------------------
    syn_info_t         info2_next;
    syn_info_t         info2_reg;
    logic [WORD_W-1:0] cw2_reg;
    cmd_t              cmd2_reg;
    code_sel_t         code2_reg;

    hsc_syndrome u_syndrome (
        .code (code1_reg),
        .cw   (cw1_reg),
        .info (info2_next)
    );

    always_ff @(posedge clk)
    begin
        if (v1_reg && st2_ready) begin
            info2_reg <= info2_next;
            cw2_reg   <= cw1_reg;
            cmd2_reg  <= cmd1_reg;
            code2_reg <= code1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: insert parity bits (encode), or correct / flag and pull
    // the data bits back out (decode).
    // ---------------------------------------------------------------
    code_desc_t        desc3;
    logic [WORD_W-1:0] enc_cw;
    logic [WORD_W-1:0] fixed_cw;
    logic [WORD_W-1:0] flip;
    logic [SYN_W-1:0]  top_idx;
    logic [WORD_W-1:0] word_next;
    logic              corr_next;
    logic [POS_W-1:0]  pos_next;
    logic              unc_next;
    logic              syn_nz;

    assign desc3   = code_desc(code2_reg);
    assign top_idx = SYN_W'(desc3.length - POS_W'(1));
    assign syn_nz  = (info2_reg.syn != '0);

    always_comb
    begin
        enc_cw = cw2_reg;
        for (int j = 0; j < SYN_W; j++) begin
            enc_cw[(1 << j) - 1] = info2_reg.syn[j];
        end
        if (desc3.ext) begin
            enc_cw[top_idx] = info2_reg.par ^ (^info2_reg.syn);
        end

        flip = '0;
        if (syn_nz) begin
            flip[info2_reg.syn - SYN_W'(1)] = 1'b1;
        end
        fixed_cw = cw2_reg ^ flip;

        word_next = '0;
        corr_next = 1'b0;
        pos_next  = '0;
        unc_next  = 1'b0;
        if (desc3.valid) begin
            if (cmd2_reg == CMD_ENCODE) begin
                word_next = enc_cw;
            end else if (desc3.ext && syn_nz && !info2_reg.par) begin
                // double error: report and drop the data
                unc_next = 1'b1;
            end else begin
                word_next = gather(fixed_cw) & data_mask(desc3);
                if (syn_nz) begin
                    corr_next = 1'b1;
                    pos_next  = {1'b0, info2_reg.syn};
                end else if (desc3.ext && info2_reg.par) begin
                    // the overall parity bit itself was wrong
                    corr_next = 1'b1;
                    pos_next  = desc3.length;
                end
            end
        end
    end

    logic [WORD_W-1:0] word_reg;
    logic              corr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              unc_reg;

    always_ff @(posedge clk)
    begin
        if (v2_reg && st3_ready) begin
            word_reg <= word_next;
            corr_reg <= corr_next;
            pos_reg  <= pos_next;
            unc_reg  <= unc_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = {unc_reg, pos_reg, corr_reg};

endmodule

// ===== rtl/hsc_checker.sv =====
// Port-level checks on the result stream of the Hamming SECDED codec.
// Depends on hsc_pkg; bound to hamming_secded_codec below.
module hsc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [hsc_pkg::WORD_W-1:0]  m_tdata,
    input logic [hsc_pkg::USER_W-1:0]  m_tuser
);
    import hsc_pkg::*;

    // hold a stalled result word unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[7]))
        else $error("corrected and uncorrectable both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser[6:1] != '0) == m_tuser[0]) && (m_tuser[6:1] <= 6'd32))
        else $error("error position disagrees with corrected flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[7] |-> (m_tdata == '0))
        else $error("uncorrectable word carries data");

endmodule

bind hamming_secded_codec hsc_checker u_hsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
